// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checksum RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/dmcsum_pkg.sv =====
// Types, constants and table function for the dual-mode stream checksum.
package dmcsum_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] SignBit = 32'h80000000;

  typedef enum logic {
    MODE_WORD = 1'b0,
    MODE_CRC  = 1'b1
  } mode_e;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_SEED = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       end_of_block;
  } beat_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic [1:0]  word_fill;
    logic        block_done;
  } result_t;

  typedef struct packed {
    logic  step;
    mode_e mode;
  } core_ctrl_t;

  function automatic logic [31:0] poly_if_lsb(input logic [31:0] v);
    return v[0] ? CrcPoly : 32'h0;
  endfunction

  // One logical shift step, then seven arithmetic shift steps.
  function automatic logic [31:0] table_word(input logic [7:0] idx);
    logic [31:0] v;
    v = {24'h0, idx};
    v = (v >> 1) ^ poly_if_lsb(v);
    for (int k = 1; k < 8; k++) begin
      v = ((v >> 1) | (v & SignBit)) ^ poly_if_lsb(v);
    end
    return v;
  endfunction

endpackage

// ===== hdl/dmcsum_core.sv =====
// Checksum state registers and the per-beat update logic for both modes.
`include "assert_macros.svh"

module dmcsum_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dmcsum_pkg::core_ctrl_t ctrl_i,
  input  dmcsum_pkg::beat_t      beat_i,
  input  logic [31:0]            seed_i,
  output dmcsum_pkg::result_t    res_o
);

  logic [31:0] acc_q, acc_d, acc_cur;
  logic [23:0] part_q, part_d, part_cur;
  logic [1:0]  fill_q, fill_d, fill_cur;
  logic [31:0] run;
  logic [7:0]  idx;

  always_comb begin
    acc_cur  = beat_i.restart ? seed_i : acc_q;
    part_cur = beat_i.restart ? 24'h0 : part_q;
    fill_cur = beat_i.restart ? 2'd0 : fill_q;
    run      = ~acc_cur;
    idx      = beat_i.data_byte ^ run[7:0];
    acc_d    = acc_cur;
    part_d   = part_cur;
    fill_d   = fill_cur;
    case (ctrl_i.mode)
      dmcsum_pkg::MODE_WORD: begin
        if (fill_cur == 2'd3) begin
          acc_d  = {acc_cur[0], acc_cur[31:1]} + {beat_i.data_byte, part_cur};
          part_d = 24'h0;
          fill_d = 2'd0;
        end else begin
          case (fill_cur)
            2'd0:    part_d = {part_cur[23:8], beat_i.data_byte};
            2'd1:    part_d = {part_cur[23:16], beat_i.data_byte, part_cur[7:0]};
            default: part_d = {beat_i.data_byte, part_cur[15:0]};
          endcase
          fill_d = fill_cur + 2'd1;
        end
      end
      dmcsum_pkg::MODE_CRC: begin
        acc_d = ~((run >> 8) ^ dmcsum_pkg::table_word(idx));
      end
      default: acc_d = acc_cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 32'h0;
      part_q <= 24'h0;
      fill_q <= 2'd0;
    end else if (ctrl_i.step) begin
      acc_q  <= acc_d;
      part_q <= part_d;
      fill_q <= fill_d;
    end
  end

  assign res_o.checksum   = acc_d;
  assign res_o.word_fill  = fill_d;
  assign res_o.block_done = beat_i.end_of_block;

  // fill is frozen in CRC mode unless a restart clears it
  `ASSERT_RST(a_crc_fill_frozen, clk_i, rst_ni,
    (ctrl_i.step && ctrl_i.mode == dmcsum_pkg::MODE_CRC && !beat_i.restart) |=> $stable(fill_q))
  `ASSERT_RST(a_restart_word_fill, clk_i, rst_ni,
    (ctrl_i.step && ctrl_i.mode == dmcsum_pkg::MODE_WORD && beat_i.restart) |=> fill_q == 2'd1)
  `ASSERT_RST(a_idle_holds_state, clk_i, rst_ni,
    !ctrl_i.step |=> ($stable(acc_q) && $stable(part_q) && $stable(fill_q)))

endmodule

// ===== hdl/dual_mode_stream_checksum.sv =====
// Top level: config registers, input and output beat registers around the checksum core.
//
// Byte-serial checksum: one data byte per beat, one result beat per input beat,
// sustained at one beat per clock while the output is not stalled. An accepted
// beat sits in the input register, the checksum update (rotate-add word mode or
// modified reflected CRC-32 with its table word generated on the fly) is done
// combinationally from it, and the result is loaded into the output register at
// the next edge at which the output can advance. A stalled output holds the input
// register and drops s_axis_tready once both registers are full. Throughput is
// set by the combinational update of the 32-bit accumulator. tuser restart
// reloads the seed before the byte is used. Configuration writes must only be
// made while no beat is in flight.
`include "assert_macros.svh"

module dual_mode_stream_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] checksum, [33:32] word_fill, rest zero
  output logic        m_axis_tlast
);

  dmcsum_pkg::mode_e      mode_q;
  logic [31:0]            seed_q;
  logic                   in_valid_q, out_valid_q, advance;
  dmcsum_pkg::beat_t      beat_q;
  dmcsum_pkg::result_t    res, res_q;
  dmcsum_pkg::core_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dmcsum_pkg::MODE_WORD;
      seed_q <= 32'h0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dmcsum_pkg::REG_MODE: mode_q <= dmcsum_pkg::mode_e'(cfg_data_i[0]);
        dmcsum_pkg::REG_SEED: seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      beat_q <= '{data_byte: s_axis_tdata, restart: s_axis_tuser, end_of_block: s_axis_tlast};
    end
    if (advance && in_valid_q) res_q <= res;
  end

  assign ctrl.step = advance && in_valid_q;
  assign ctrl.mode = mode_q;

  dmcsum_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .beat_i (beat_q),
    .seed_i (seed_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'h0, res_q.word_fill, res_q.checksum};
  assign m_axis_tlast  = res_q.block_done;

  `ASSERT_RST(a_accept_fills_input, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
  `ASSERT_RST(a_step_fills_output, clk_i, rst_ni,
    ctrl.step |=> out_valid_q)
  `ASSERT_ALWAYS(a_ready_when_empty, clk_i,
    !in_valid_q |-> s_axis_tready)

endmodule

// ===== bench/tb_dual_mode_stream_checksum.sv =====
// Self-checking testbench for dual_mode_stream_checksum: directed and random byte streams.
`timescale 1ns / 100ps

module tb_dual_mode_stream_checksum;

  localparam int PipeDepth  = 2;
  localparam int StallLimit = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  dual_mode_stream_checksum u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // checksum model state and register shadows
  dmcsum_pkg::mode_e sh_mode;
  logic [31:0]       sh_seed;
  logic [31:0]       mdl_acc;
  logic [23:0]       mdl_pword;
  logic [1:0]        mdl_fill;

  dmcsum_pkg::result_t sum_expected_q[$];
  int                  n_mismatch;
  int                  src_idle_pct;
  int                  dst_idle_pct;
  int                  stall_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
    logic [31:0] v;
    logic        lsb;
    v   = {24'h0, idx};
    lsb = v[0];
    v   = {1'b0, v[31:1]} ^ (lsb ? dmcsum_pkg::CrcPoly : 32'h0);
    for (int k = 1; k < 8; k++) begin
      lsb = v[0];
      v   = {v[31], v[31:1]} ^ (lsb ? dmcsum_pkg::CrcPoly : 32'h0);
    end
    return v;
  endfunction

  task automatic predict_checksum(input logic [7:0] b, input logic rs, input logic eob);
    logic [31:0]         run;
    logic [31:0]         word;
    dmcsum_pkg::result_t res;
    if (rs) begin
      mdl_acc   = sh_seed;
      mdl_pword = '0;
      mdl_fill  = '0;
    end
    if (sh_mode == dmcsum_pkg::MODE_WORD) begin
      if (mdl_fill == 2'd3) begin
        word      = {b, mdl_pword};
        mdl_acc   = {mdl_acc[0], mdl_acc[31:1]} + word;
        mdl_pword = '0;
        mdl_fill  = '0;
      end else begin
        mdl_pword = mdl_pword | (24'(b) << (8 * mdl_fill));
        mdl_fill  = mdl_fill + 2'd1;
      end
    end else begin
      run     = ~mdl_acc;
      run     = (run >> 8) ^ crc_table_entry(b ^ run[7:0]);
      mdl_acc = ~run;
    end
    res.checksum     = mdl_acc;
    res.word_fill    = mdl_fill;
    res.block_done   = eob;
    sum_expected_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
    n_mismatch++;
  endtask

  task automatic send_beat(input logic [7:0] b, input logic rs, input logic eob);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_checksum(b, rs, eob);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sum_expected_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  task automatic cfg_write(input dmcsum_pkg::reg_idx_e idx, input logic [31:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dmcsum_pkg::REG_MODE) sh_mode = dmcsum_pkg::mode_e'(data[0]);
    else                             sh_seed = data;
    @(posedge clk_i);
  endtask

  task automatic test_word_mode();
    cfg_write(dmcsum_pkg::REG_SEED, 32'hFFFF_FFFF);
    cfg_write(dmcsum_pkg::REG_MODE, 32'(dmcsum_pkg::MODE_WORD));
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_restart_mid_word();
    send_beat(8'h12, 1'b0, 1'b0);
    send_beat(8'h34, 1'b0, 1'b0);
    send_beat(8'h56, 1'b0, 1'b0);
    send_beat(8'h78, 1'b1, 1'b1);
  endtask

  // inversion must cancel across buffer boundaries
  task automatic test_crc_mode();
    cfg_write(dmcsum_pkg::REG_SEED, 32'h0);
    cfg_write(dmcsum_pkg::REG_MODE, 32'(dmcsum_pkg::MODE_CRC));
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b1);
    send_beat(8'h01, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b1);
    cfg_write(dmcsum_pkg::REG_SEED, 32'hFFFF_FFFF);
    send_beat(8'hAA, 1'b1, 1'b1);
  endtask

  // partial word frozen in CRC mode, finished later; wide mode writes keep bit 0 only
  task automatic test_mode_switch();
    cfg_write(dmcsum_pkg::REG_MODE, 32'hFFFF_FFFE);
    send_beat(8'h11, 1'b1, 1'b0);
    send_beat(8'h22, 1'b0, 1'b0);
    cfg_write(dmcsum_pkg::REG_MODE, 32'hFFFF_FFFF);
    send_beat(8'h33, 1'b0, 1'b0);
    send_beat(8'h44, 1'b0, 1'b0);
    cfg_write(dmcsum_pkg::REG_MODE, 32'hFFFF_FFFE);
    send_beat(8'h55, 1'b0, 1'b0);
    send_beat(8'h66, 1'b0, 1'b1);
  endtask

  task automatic test_random_buffers(input int n_items);
    int   sent;
    int   len;
    bit   noisy;
    logic rs;
    logic eob;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(dmcsum_pkg::REG_MODE,
                  ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
          0:       cfg_write(dmcsum_pkg::REG_SEED, 32'h0);
          1:       cfg_write(dmcsum_pkg::REG_SEED, 32'hFFFF_FFFF);
          default: cfg_write(dmcsum_pkg::REG_SEED, $urandom);
        endcase
      end
      len   = $urandom_range(1, 12);
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        if (noisy) begin
          rs  = 1'($urandom_range(0, 1));
          eob = 1'($urandom_range(0, 1));
        end else begin
          rs  = (k == 0);
          eob = (k == len - 1);
        end
        send_beat(8'($urandom), rs, eob);
        sent++;
      end
    end
  endtask

  // result check and random backpressure
  always @(posedge clk_i) begin
    dmcsum_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sum_expected_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = sum_expected_q.pop_front();
        if (m_axis_tdata[31:0] !== want.checksum)
          report_mismatch("checksum", m_axis_tdata[31:0], want.checksum);
        if (m_axis_tdata[33:32] !== want.word_fill)
          report_mismatch("word_fill", 32'(m_axis_tdata[33:32]), 32'(want.word_fill));
        if (m_axis_tlast !== want.block_done)
          report_mismatch("block_done", 32'(m_axis_tlast), 32'(want.block_done));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = dmcsum_pkg::REG_MODE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    n_mismatch    = 0;
    sh_mode       = dmcsum_pkg::MODE_WORD;
    sh_seed       = '0;
    mdl_acc       = '0;
    mdl_pword     = '0;
    mdl_fill      = '0;
    src_idle_pct  = 6;
    dst_idle_pct  = 85;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_word_mode();
    test_restart_mid_word();
    test_crc_mode();
    test_mode_switch();
    test_random_buffers(220);

    wait_idle();
    src_idle_pct = 85;
    dst_idle_pct = 6;
    test_random_buffers(220);

    wait_idle();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_buffers(210);

    wait_idle();
    if (n_mismatch == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
